// ===== design/uvs_pkg.sv =====
// uvs_pkg: shared types, constants and helpers of the UV sphere vertex core.
// Standalone package; used by uvs_div, uvs_sin and the top level.
package uvs_pkg;

  localparam int unsigned MAX_SEGMENTS_DEF = 255;

  localparam int unsigned CNT_W   = 8;
  localparam int unsigned RAD_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned Q15_W   = 16;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned PH_W    = 20;

  // divider: numerator, divisor, remainder, quotient widths
  localparam int unsigned NUM_W   = 29;
  localparam int unsigned DEN_W   = 9;
  localparam int unsigned REM_W   = 10;
  localparam int unsigned QUO_W   = 21;

  localparam int unsigned DIV_LAT  = QUO_W;
  localparam int unsigned SIN_LAT  = 22;
  localparam int unsigned POST_LAT = 3;
  localparam int unsigned PIPE_DEPTH = DIV_LAT + SIN_LAT + POST_LAT;

  // pi in Q32, split at bit 17
  localparam logic [16:0] PI_HI = 17'd102943;
  localparam logic [16:0] PI_LO = 17'd92809;

  localparam int unsigned N_TERMS = 5;
  localparam logic [6:0]  TERM_K [N_TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  // floor(2^32 / k)
  localparam logic [29:0] TERM_M [N_TERMS] =
    '{30'd39045157, 30'd59652323, 30'd102261126, 30'd214748364, 30'd715827882};

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [1:0] {
    CFG_RING   = 2'd0,
    CFG_STACK  = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [Q15_W-1:0] bitangent_z;
    logic signed [Q15_W-1:0] bitangent_y;
    logic signed [Q15_W-1:0] bitangent_x;
    logic signed [Q15_W-1:0] tangent_y;
    logic signed [Q15_W-1:0] tangent_x;
    logic signed [Q15_W-1:0] normal_z;
    logic signed [Q15_W-1:0] normal_y;
    logic signed [Q15_W-1:0] normal_x;
    logic signed [POS_W-1:0] pos_z;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_x;
  } vtx_t;

  function automatic logic [14:0] abs15(logic signed [Q15_W-1:0] a);
    logic signed [Q15_W-1:0] n;
    n = -a;
    return a[Q15_W-1] ? n[14:0] : a[14:0];
  endfunction

  function automatic logic signed [Q15_W-1:0] apply_sign(logic [14:0] m, logic neg);
    logic signed [Q15_W-1:0] v;
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

  // Q1.15 product of two magnitudes with rounding
  function automatic logic [14:0] rnd_q15(logic [29:0] p);
    logic [30:0] s;
    s = {1'b0, p} + 31'd16384;
    return s[29:15];
  endfunction

endpackage

// ===== design/uvs_div.sv =====
// uvs_div: pipelined restoring divider, one quotient bit per stage.
// Uses uvs_pkg widths; divisor is held stable by the caller.
module uvs_div import uvs_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [REM_W-1:0] rem_q [QUO_W];
  logic [REM_W-1:0] rem_d [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [QUO_W-1:0] low_d [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] quo_d [QUO_W];

  always_comb begin
    logic [REM_W-1:0] r_in;
    logic [QUO_W-1:0] l_in;
    logic [QUO_W-1:0] q_in;
    logic [REM_W-1:0] t;
    for (int i = 0; i < QUO_W; i++) begin
      if (i == 0) begin
        r_in = {{(REM_W-(NUM_W-QUO_W)){1'b0}}, num_i[NUM_W-1:QUO_W]};
        l_in = num_i[QUO_W-1:0];
        q_in = '0;
      end else begin
        r_in = rem_q[i-1];
        l_in = low_q[i-1];
        q_in = quo_q[i-1];
      end
      t = {r_in[REM_W-2:0], l_in[QUO_W-1]};
      if (t >= {1'b0, den_i}) begin
        rem_d[i] = t - {1'b0, den_i};
        quo_d[i] = {q_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_d[i] = t;
        quo_d[i] = {q_in[QUO_W-2:0], 1'b0};
      end
      low_d[i] = {l_in[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < QUO_W; i++) begin
        rem_q[i] <= rem_d[i];
        low_q[i] <= low_d[i];
        quo_q[i] <= quo_d[i];
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// ===== design/uvs_sin.sv =====
// uvs_sin: pipelined fixed-point sine of a 20-bit turn phase, Q1.15 result.
// Uses uvs_pkg constants; every pipeline register advances only while en_i is high.
module uvs_sin import uvs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [PH_W-1:0]         phase_i,
  output logic signed [Q15_W-1:0] sin_o
);

  typedef struct packed {
    logic [30:0] x;
    logic [31:0] x2;
    logic        neg;
  } ctx_t;

  // front end
  logic [18:0] t_q;
  logic        ng0_q, ng1_q, ng2_q, ng3_q;
  logic [35:0] hi_q, lo_q;
  logic [30:0] x2s_q, x3s_q;
  logic [61:0] xx_q;
  ctx_t        ctx4_q;

  // polynomial terms: multiply, reciprocal, correct
  logic [62:0] pr_q  [N_TERMS];
  ctx_t        ctxa_q[N_TERMS];
  logic [31:0] y_q   [N_TERMS];
  logic [31:0] q0_q  [N_TERMS];
  ctx_t        ctxb_q[N_TERMS];
  logic [30:0] acc_q [N_TERMS];
  ctx_t        ctxc_q[N_TERMS];

  logic [61:0] sp_q;
  logic        ngf_q;

  logic [18:0] t_d;
  logic [52:0] xsum;
  logic [62:0] x2sum;

  always_comb begin
    logic [17:0] r;
    r = phase_i[17:0];
    t_d = phase_i[18] ? (19'h40000 - {1'b0, r}) : {1'b0, r};
  end

  assign xsum  = {hi_q, 17'b0} + {17'b0, lo_q} + 53'h10_0000;
  assign x2sum = {1'b0, xx_q} + 63'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      ng0_q  <= phase_i[19];
      hi_q   <= t_q * PI_HI;
      lo_q   <= t_q * PI_LO;
      ng1_q  <= ng0_q;
      x2s_q  <= xsum[51:21];
      ng2_q  <= ng1_q;
      xx_q   <= x2s_q * x2s_q;
      x3s_q  <= x2s_q;
      ng3_q  <= ng2_q;
      ctx4_q <= '{x: x3s_q, x2: x2sum[61:30], neg: ng3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    logic [30:0] a_in;
    logic [61:0] ym;
    logic [31:0] qk;
    logic [31:0] rr;
    logic [31:0] qf;
    if (en_i) begin
      for (int i = 0; i < N_TERMS; i++) begin
        a_in = (i == 0) ? ONE_Q30 : acc_q[i-1];
        pr_q[i]   <= ((i == 0) ? ctx4_q.x2 : ctxc_q[i-1].x2) * a_in;
        ctxa_q[i] <= (i == 0) ? ctx4_q : ctxc_q[i-1];
        ym = pr_q[i][61:30] * TERM_M[i];
        y_q[i]    <= pr_q[i][61:30];
        q0_q[i]   <= {2'b0, ym[61:32]};
        ctxb_q[i] <= ctxa_q[i];
        qk = q0_q[i] * TERM_K[i];
        rr = y_q[i] - qk;
        qf = (rr >= {25'b0, TERM_K[i]}) ? q0_q[i] + 32'd1 : q0_q[i];
        acc_q[i]  <= ONE_Q30 - qf[30:0];
        ctxc_q[i] <= ctxb_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] m;
    logic [14:0] ms;
    if (en_i) begin
      sp_q  <= ctxc_q[N_TERMS-1].x * acc_q[N_TERMS-1];
      ngf_q <= ctxc_q[N_TERMS-1].neg;
      m  = {1'b0, sp_q[60:30]} + 32'd16384;
      ms = (m[31:15] > 17'd32767) ? 15'h7fff : m[29:15];
      sin_o <= apply_sign(ms, ngf_q);
    end
  end

endmodule

// ===== design/uv_sphere_vertex_generator_core.sv =====
// uv_sphere_vertex_generator_core: UV sphere grid point to vertex attributes.
// Depends on uvs_pkg, uvs_div (phase dividers) and uvs_sin (four sine units).
//
//  channel   dir  payload                               transfer when
//  s_axis    in   tdata[15:0]  stack, ring indices      tvalid & tready
//  m_axis    out  tdata[199:0] pos, normal, tan, bitan  tvalid & tready
//  cfg       in   cfg_idx_i, cfg_data_i                 cfg_we_i
//
// One item per cycle sustained while the output queue is not full. Depth is
// set by the 21-stage phase divider, the 22-stage sine pipeline and the post
// stages. A two-entry output queue holds results; the pipeline advances
// whenever the queue is not full. Reset clears valid bits and loads register
// defaults; no clearing pass.
module uv_sphere_vertex_generator_core import uvs_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // stack_index[7:0], ring_index[15:8]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // pos_x, pos_y, pos_z (24 each), normal_x/y/z, tangent_x/y, bitangent_x/y/z
  output logic [199:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [CNT_W-1:0] ring_q, stack_q;
  logic [RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_q   <= CNT_W'(16);
      stack_q  <= CNT_W'(16);
      radius_q <= RAD_W'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RING:   ring_q   <= cfg_data_i[CNT_W-1:0];
        CFG_STACK:  stack_q  <= cfg_data_i[CNT_W-1:0];
        CFG_RADIUS: radius_q <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [CNT_W-1:0] clamp_cnt(logic [CNT_W-1:0] n);
    if (n == '0) return CNT_W'(1);
    if (n > CNT_W'(MAX_SEGMENTS)) return CNT_W'(MAX_SEGMENTS);
    return n;
  endfunction

  logic [CNT_W-1:0] rings, stacks, st, rg;
  logic [NUM_W-1:0] num_pp, num_pa;

  always_comb begin
    rings  = clamp_cnt(ring_q);
    stacks = clamp_cnt(stack_q);
    st = (s_axis_tdata[7:0]  > stacks) ? stacks : s_axis_tdata[7:0];
    rg = (s_axis_tdata[15:8] > rings)  ? rings  : s_axis_tdata[15:8];
    num_pp = {1'b0, st, 20'b0} + {21'b0, stacks};
    num_pa = {rg, 21'b0} + {21'b0, rings};
  end

  logic en;
  logic [PIPE_DEPTH-1:0] v_q;

  logic [QUO_W-1:0] quo_pp, quo_pa;

  uvs_div u_div_pp (
    .clk_i (clk_i), .en_i (en), .num_i (num_pp),
    .den_i ({stacks, 1'b0}), .quo_o (quo_pp)
  );

  uvs_div u_div_pa (
    .clk_i (clk_i), .en_i (en), .num_i (num_pa),
    .den_i ({rings, 1'b0}), .quo_o (quo_pa)
  );

  localparam logic [PH_W-1:0] PH_QTR = PH_W'(1) << (PH_W - 2);

  logic [PH_W-1:0] pp, pa;
  logic signed [Q15_W-1:0] sp, cp, sa, ca;

  assign pp = quo_pp[PH_W-1:0];
  assign pa = quo_pa[PH_W-1:0];

  uvs_sin u_sin_p (.clk_i (clk_i), .en_i (en), .phase_i (pp),          .sin_o (sp));
  uvs_sin u_cos_p (.clk_i (clk_i), .en_i (en), .phase_i (pp + PH_QTR), .sin_o (cp));
  uvs_sin u_sin_a (.clk_i (clk_i), .en_i (en), .phase_i (pa),          .sin_o (sa));
  uvs_sin u_cos_a (.clk_i (clk_i), .en_i (en), .phase_i (pa + PH_QTR), .sin_o (ca));

  // post stage 1: magnitude products
  logic [29:0] pnx_q, pny_q, pbx_q, pby_q;
  logic        snx_q, sny_q, sbx_q, sby_q;
  logic signed [Q15_W-1:0] sa1_q, ca1_q, sp1_q, cp1_q;
  // post stage 2: Q1.15 vectors
  vtx_t v2_d;
  vtx_t v2_q;
  // post stage 3: scaled magnitudes
  vtx_t v3_q;
  logic [30:0] mx_q, my_q, mz_q;

  always_comb begin
    v2_d = '0;
    v2_d.normal_x    = apply_sign(rnd_q15(pnx_q), snx_q);
    v2_d.normal_y    = apply_sign(rnd_q15(pny_q), sny_q);
    v2_d.normal_z    = cp1_q;
    v2_d.tangent_x   = -sa1_q;
    v2_d.tangent_y   = ca1_q;
    v2_d.bitangent_x = apply_sign(rnd_q15(pbx_q), sbx_q);
    v2_d.bitangent_y = apply_sign(rnd_q15(pby_q), sby_q);
    v2_d.bitangent_z = -sp1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pnx_q <= abs15(ca) * abs15(sp);
      pny_q <= abs15(sa) * abs15(sp);
      pbx_q <= abs15(ca) * abs15(cp);
      pby_q <= abs15(sa) * abs15(cp);
      snx_q <= ca[Q15_W-1] ^ sp[Q15_W-1];
      sny_q <= sa[Q15_W-1] ^ sp[Q15_W-1];
      sbx_q <= ca[Q15_W-1] ^ cp[Q15_W-1];
      sby_q <= sa[Q15_W-1] ^ cp[Q15_W-1];
      sa1_q <= sa;
      ca1_q <= ca;
      sp1_q <= sp;
      cp1_q <= cp;

      v2_q <= v2_d;

      v3_q <= v2_q;
      mx_q <= abs15(v2_q.normal_x) * radius_q;
      my_q <= abs15(v2_q.normal_y) * radius_q;
      mz_q <= abs15(v2_q.normal_z) * radius_q;
    end
  end

  function automatic logic signed [POS_W-1:0] pos_of(logic [30:0] m, logic neg);
    logic [31:0] s;
    logic signed [POS_W-1:0] v;
    s = {1'b0, m} + 32'd128;
    v = s[31:8];
    return neg ? -v : v;
  endfunction

  vtx_t res;
  always_comb begin
    res = v3_q;
    res.pos_x = pos_of(mx_q, v3_q.normal_x[Q15_W-1]);
    res.pos_y = pos_of(my_q, v3_q.normal_y[Q15_W-1]);
    res.pos_z = pos_of(mz_q, v3_q.normal_z[Q15_W-1]);
  end

  // output queue
  vtx_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign en   = (cnt_q != 2'd2);
  assign push = en && v_q[PIPE_DEPTH-1];
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (en) v_q <= {v_q[PIPE_DEPTH-2:0], s_axis_tvalid};
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= res;
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = mem_q[rd_q];

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("output queue count out of range");
  a_push_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q != 2'd0) else $error("pushed result lost");
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q)) else $error("pipeline moved while stalled");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wr_q == rd_q)
    else $error("queue pointers inconsistent");
`endif

endmodule
